[design/ffca_pkg.sv]
// ----------------------------------------------------------------------------
// ffca_pkg
// Transaction types, operation codes and controller states shared by the
// first-fit cell allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned FADDR_W = 4;
  localparam int unsigned BADDR_W = 4;
  localparam int unsigned MAP_W   = 16;

  // Product of count_items and item_size, kept at full width.
  localparam int unsigned PROD_W  = COUNT_W + SIZE_W;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] count_items;
    logic [SIZE_W-1:0]  item_size;
    logic [FADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [BADDR_W-1:0] block_addr;
    logic               fail;
    logic [MAP_W-1:0]   used_map;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_FREE_RD,
    ST_FREE_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[design/first_fit_cell_allocator.sv]
// Allocate: the first free run long enough is found by a scan and then filled; an
// allocation that finds no run long enough fails. Free: every cell holding the tag of
// the named cell is cleared; freeing a free cell, or a zero-sized, oversized or
// out-of-range request, ends without a scan. The result is registered as the block
// returns to idle, and a stalled result holds the block in its final state.
// Reset clears the per-cell used flags, so every cell reads as free; no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_cell_allocator
// Keeps an owner tag per cell in a synchronous memory and serves first-fit
// allocate and free-by-tag requests by scanning the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_cell_allocator #(
  parameter int unsigned CELLS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ffca_pkg::req_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ffca_pkg::rsp_t       out_data_o
);

  // Cell index width, and the width of a count that can hold CELLS itself.
  // A tag is start + 1, so it fits in the count width as well.
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned TAG_W  = CNT_W;
  localparam int unsigned CMP_W  = 8;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);

  // --------------------------------------------------------------------------
  // Owner memory and used flags.
  // The memory holds the owner tag of each cell. The used flags are the
  // valid bits of the memory: reset clears them, so a cell whose flag is low
  // reads as tag zero whatever the memory holds. They also give the bitmap.
  // --------------------------------------------------------------------------
  logic [TAG_W-1:0]  owner_mem [CELLS];
  logic [CELLS-1:0]  used_q;

  logic [ADDR_W-1:0] rd_addr;
  logic [TAG_W-1:0]  rd_data_q;
  logic              rd_used_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [TAG_W-1:0]  wr_data;
  logic              wr_used;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      owner_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (wr_en) begin
        used_q[wr_addr] <= wr_used;
      end
      rd_used_q <= used_q[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Controller registers.
  // --------------------------------------------------------------------------
  ffca_pkg::state_e  state_q, state_d;

  logic [ADDR_W-1:0] scan_q, scan_d;           // next cell to read
  logic              iss_on_q, iss_on_d;       // reads still to be issued
  logic              chk_vld_q, chk_vld_d;     // read data in flight is valid
  logic [ADDR_W-1:0] chk_idx_q, chk_idx_d;     // cell whose data arrives now
  logic [CNT_W-1:0]  run_q, run_d;             // length of the current free run
  logic [ADDR_W-1:0] run_start_q, run_start_d; // first cell of that run
  logic [CNT_W-1:0]  need_q, need_d;           // cells requested
  logic [ADDR_W-1:0] start_q, start_d;         // start of the placed block
  logic [ADDR_W-1:0] fill_idx_q, fill_idx_d;
  logic [CNT_W-1:0]  fill_left_q, fill_left_d;
  logic [TAG_W-1:0]  goal_q, goal_d;           // tag being freed
  logic              res_fail_q, res_fail_d;

  logic              out_valid_q, out_valid_d;
  ffca_pkg::rsp_t    out_q, out_d;

  // --------------------------------------------------------------------------
  // Request decode.
  // --------------------------------------------------------------------------
  logic                        in_accept;
  logic [ffca_pkg::PROD_W-1:0] prod;
  logic                        need_ok;
  logic                        faddr_ok;
  logic [ADDR_W+3:0]           faddr_ext;
  logic [ADDR_W-1:0]           faddr_idx;

  assign in_stall_o = (state_q != ffca_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign prod     = ffca_pkg::PROD_W'(in_data_i.count_items) *
                    ffca_pkg::PROD_W'(in_data_i.item_size);
  assign need_ok  = (prod != '0) && (prod <= ffca_pkg::PROD_W'(CELLS));
  assign faddr_ok = (CMP_W'(in_data_i.free_addr) < CMP_W'(CELLS));

  assign faddr_ext = {{ADDR_W{1'b0}}, in_data_i.free_addr};
  assign faddr_idx = faddr_ext[ADDR_W-1:0];

  // --------------------------------------------------------------------------
  // Scan status. Read data arrives in the cycle after its address; chk_idx_q
  // names the cell that it belongs to.
  // --------------------------------------------------------------------------
  logic             cell_free;
  logic [CNT_W-1:0] run_inc;
  logic             hit;
  logic             last_chk;
  logic [TAG_W-1:0] owner_rd;
  logic             out_free;

  assign cell_free = !rd_used_q;
  assign run_inc   = run_q + CNT_W'(1);
  assign hit       = chk_vld_q && cell_free && (run_inc == need_q);
  assign last_chk  = chk_vld_q && (chk_idx_q == LAST_IDX);
  assign owner_rd  = rd_used_q ? rd_data_q : '0;
  assign out_free  = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffca_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.func == ffca_pkg::FUNC_FREE) begin
            state_d = faddr_ok ? ffca_pkg::ST_FREE_RD : ffca_pkg::ST_DONE;
          end else begin
            state_d = need_ok ? ffca_pkg::ST_SCAN : ffca_pkg::ST_DONE;
          end
        end
      end
      ffca_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = ffca_pkg::ST_FILL;
        end else if (last_chk) begin
          state_d = ffca_pkg::ST_DONE;
        end
      end
      ffca_pkg::ST_FILL: begin
        if (fill_left_q == CNT_W'(1)) begin
          state_d = ffca_pkg::ST_DONE;
        end
      end
      ffca_pkg::ST_FREE_RD: begin
        state_d = (owner_rd == '0) ? ffca_pkg::ST_DONE : ffca_pkg::ST_FREE_SCAN;
      end
      ffca_pkg::ST_FREE_SCAN: begin
        if (last_chk) begin
          state_d = ffca_pkg::ST_DONE;
        end
      end
      ffca_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ffca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffca_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control.
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] hit_start;
  logic [ADDR_W+3:0] addr_ext;
  logic [CELLS+15:0] used_ext;

  assign hit_start = (run_q == '0) ? chk_idx_q : run_start_q;
  assign addr_ext  = {4'b0, start_q};
  assign used_ext  = {16'b0, used_q};

  always_comb begin
    scan_d      = scan_q;
    iss_on_d    = iss_on_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    run_d       = run_q;
    run_start_d = run_start_q;
    need_d      = need_q;
    start_d     = start_q;
    fill_idx_d  = fill_idx_q;
    fill_left_d = fill_left_q;
    goal_d      = goal_q;
    res_fail_d  = res_fail_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    wr_used = 1'b0;

    case (state_q)
      ffca_pkg::ST_IDLE: begin
        if (in_accept) begin
          res_fail_d = (in_data_i.func == ffca_pkg::FUNC_ALLOC) && !need_ok;
          start_d    = '0;
          need_d     = prod[CNT_W-1:0];
          scan_d     = '0;
          iss_on_d   = 1'b1;
          run_d      = '0;
          // The tag of the cell to free is read straight away.
          rd_addr    = faddr_idx;
        end
      end
      ffca_pkg::ST_SCAN, ffca_pkg::ST_FREE_SCAN: begin
        if (iss_on_q) begin
          rd_addr   = scan_q;
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q;
          scan_d    = scan_q + ADDR_W'(1);
          if (scan_q == LAST_IDX) begin
            iss_on_d = 1'b0;
          end
        end
        if (state_q == ffca_pkg::ST_SCAN) begin
          if (chk_vld_q) begin
            if (cell_free) begin
              run_d = run_inc;
              if (run_q == '0) begin
                run_start_d = chk_idx_q;
              end
            end else begin
              run_d = '0;
            end
          end
          if (hit) begin
            start_d     = hit_start;
            fill_idx_d  = hit_start;
            fill_left_d = need_q;
          end else if (last_chk) begin
            res_fail_d = 1'b1;
          end
        end else begin
          // Clearing a cell writes behind the read pointer, which is always
          // one cell ahead, so no entry is read and written at once.
          if (chk_vld_q && rd_used_q && (rd_data_q == goal_q)) begin
            wr_en   = 1'b1;
            wr_addr = chk_idx_q;
            wr_data = '0;
            wr_used = 1'b0;
          end
        end
      end
      ffca_pkg::ST_FILL: begin
        wr_en       = 1'b1;
        wr_addr     = fill_idx_q;
        wr_data     = TAG_W'(start_q) + TAG_W'(1);
        wr_used     = 1'b1;
        fill_idx_d  = fill_idx_q + ADDR_W'(1);
        fill_left_d = fill_left_q - CNT_W'(1);
      end
      ffca_pkg::ST_FREE_RD: begin
        goal_d   = owner_rd;
        scan_d   = '0;
        iss_on_d = 1'b1;
      end
      ffca_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.block_addr = addr_ext[3:0];
          out_d.fail       = res_fail_q;
          out_d.used_map   = used_ext[15:0];
        end
      end
      default: begin
        chk_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffca_pkg::ST_IDLE;
      iss_on_q    <= 1'b0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_on_q    <= iss_on_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    chk_idx_q   <= chk_idx_d;
    run_q       <= run_d;
    run_start_q <= run_start_d;
    need_q      <= need_d;
    start_q     <= start_d;
    fill_idx_q  <= fill_idx_d;
    fill_left_q <= fill_left_d;
    goal_q      <= goal_d;
    res_fail_q  <= res_fail_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A block is only ever placed on cells that are free.
  a_fill_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffca_pkg::ST_FILL) |-> !used_q[fill_idx_q])
    else $error("allocation overwrites a cell in use");

  // The fill phase always has cells left to write.
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffca_pkg::ST_FILL) |-> (fill_left_q != '0))
    else $error("fill phase entered with no cells to write");

  // The read pointer never meets the cell being checked and written.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chk_vld_q && iss_on_q) |-> (scan_q != chk_idx_q))
    else $error("read and write-back address the same cell");

  // A failed allocation reports start address zero.
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fail && (out_data_o.block_addr != '0)))
    else $error("failed transaction carries a nonzero address");

  // A result is produced only on leaving the final state of a request.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ffca_pkg::ST_DONE))
    else $error("result raised outside the completion state");

endmodule

`default_nettype wire
